// ===== design/iyoc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iyoc_pkg;
    localparam int DELAY_DEPTH_DEF = 5;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANG_W = 16;
    localparam int SUM_W = 24;
    localparam int CW = 40;  // cordic datapath width
    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_PERSIST = 2'd1;
    localparam logic [1:0] REG_CALIB = 2'd2;
    localparam logic [1:0] REG_RATE = 2'd3;
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    typedef struct packed {
        logic start;
        logic vect;
    } cord_ctl_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== design/iyoc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iyoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== design/iyoc_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared CORDIC: one micro-rotation per cycle. Rotation gives Q14 cos/sin,
// vectoring gives a 16-bit binary angle.
module iyoc_cordic
    import iyoc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cord_ctl_t         ctl,
    input  wire logic [ANG_W-1:0]  ang_in,
    input  wire logic [SUM_W-1:0]  xs_in,
    input  wire logic [SUM_W-1:0]  ys_in,
    output logic                   done,
    output logic [ANG_W-1:0]       cos_out,
    output logic [ANG_W-1:0]       sin_out,
    output logic [ANG_W-1:0]       ang_out
);
    localparam int NW = $clog2(CORDIC_STEPS + 1);
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [NW-1:0] i_reg;
    logic busy_reg, vect_reg, flip_reg, zero_reg;
    logic signed [CW-1:0] dx, dy, xo, yo;
    logic signed [32:0] at;
    logic dir;
    logic [31:0] zu;
    logic signed [CW-1:0] xi, yi;

    assign dx = x_reg >>> i_reg;
    assign dy = y_reg >>> i_reg;
    assign at = {1'b0, atan_entry(5'(i_reg))};
    assign dir = vect_reg ? ~y_reg[CW-1] : ~z_reg[32];
    assign zu = {ang_in, 16'd0};
    assign xi = CW'($signed(xs_in)) <<< 6;
    assign yi = CW'($signed(ys_in)) <<< 6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                i_reg <= '0;
                vect_reg <= ctl.vect;
                zero_reg <= (xs_in == '0) && (ys_in == '0);
                if (ctl.vect)
                begin
                    flip_reg <= 1'b0;
                    x_reg <= xi[CW-1] ? -xi : xi;
                    y_reg <= xi[CW-1] ? -yi : yi;
                    z_reg <= xi[CW-1] ? 33'sh080000000 : 33'sd0;
                end
                else
                begin
                    x_reg <= CW'(CORDIC_GAIN);
                    y_reg <= '0;
                    if (zu > 32'h40000000 && zu < 32'hC0000000)
                    begin
                        flip_reg <= 1'b1;
                        z_reg <= $signed({zu[31] ^ 1'b1, zu[31] ^ 1'b1, zu[30:0]});
                    end
                    else
                    begin
                        flip_reg <= 1'b0;
                        z_reg <= $signed({zu[31], zu});
                    end
                end
            end
            else if (busy_reg)
            begin
                if (i_reg == NW'(CORDIC_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                    if (vect_reg ^ dir)
                    begin
                        x_reg <= x_reg - dy;
                        y_reg <= y_reg + dx;
                    end
                    else
                    begin
                        x_reg <= x_reg + dy;
                        y_reg <= y_reg - dx;
                    end
                    z_reg <= (dir ^ vect_reg) ? z_reg - at : z_reg + at;
                end
            end
        end
    end

    // vectoring with y>=0: x+=y>>i, y-=x>>i, z+=a ; rotation z>=0: x-=y, y+=x, z-=a
    function automatic logic [ANG_W-1:0] q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            r = (v + CW'(32768)) >>> 16;
            if (r > CW'(16384)) r = CW'(16384);
            if (r < -CW'(16384)) r = -CW'(16384);
            return r[ANG_W-1:0];
        end
    endfunction

    assign xo = flip_reg ? -x_reg : x_reg;
    assign yo = flip_reg ? -y_reg : y_reg;
    assign cos_out = q14(xo);
    assign sin_out = q14(yo);
    logic [31:0] zr;
    assign zr = z_reg[31:0] + 32'd32768;
    assign ang_out = zero_reg ? '0 : zr[31:16];
endmodule
`default_nettype wire

// ===== design/imu_yaw_offset_calibrator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// IMU yaw offset calibrator.
// s_axis carries one sample request: tuser = command (0 sample, 1 clear),
// tdata from bit 0 up: imu_yaw, vision_yaw, vision_valid, rate_of_turn.
// m_axis returns one result per request: tdata from bit 0 up: corrected_yaw,
// current_offset, calibrated_once, offset_updated.
// cfg writes registers 0..3 (threshold, persist, calib samples, rate limit).
// A clear request goes straight to the output register; a sample that does not
// accumulate passes the delay-line read and the mismatch check first; an
// accumulating sample or an offset update also takes two passes through the one
// shared CORDIC (rotation for accumulation, vectoring for the offset update).
// One request is in flight at a time. The result sits in an output register;
// a stalled receiver holds it and no new request is taken until it leaves.
// Reset clears delay line (read through valid bits), sums, counters, flags,
// and restores register defaults.
module imu_yaw_offset_calibrator
    import iyoc_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // imu_yaw, vision_yaw, vision_valid, rate_of_turn
    input  wire logic        s_axis_tuser,  // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // corrected_yaw, current_offset, calibrated_once, offset_updated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);
    localparam int DW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_CHK = 4'd2,
        ST_C1 = 4'd3, ST_W1 = 4'd4, ST_C2 = 4'd5, ST_W2 = 4'd6,
        ST_V1 = 4'd7, ST_VW1 = 4'd8, ST_V2 = 4'd9, ST_VW2 = 4'd10, ST_OUT = 4'd11;

    logic [3:0] st_reg;
    logic [14:0] thr_reg, rlim_reg;
    logic [7:0] pers_reg, cal_reg, mis_reg;
    logic [8:0] cnt_reg;
    logic signed [SUM_W-1:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic [15:0] off_reg, last_reg, imu_reg, vis_reg, rate_reg, old_reg, av_reg;
    logic valid_reg, need_reg, done_reg, upd_reg;
    logic [DW-1:0] didx_reg;
    logic [DELAY_DEPTH-1:0] dval_reg;
    logic [DW-1:0] didx_next;
    logic [15:0] ram_q;

    assign cfg_ready = (st_reg == ST_IDLE) && !m_axis_tvalid;
    assign s_axis_tready = (st_reg == ST_IDLE) && !m_axis_tvalid;
    assign didx_next = (didx_reg == DW'(DELAY_DEPTH - 1)) ? '0 : didx_reg + 1'b1;

    iyoc_ram #(.WIDTH(16), .DEPTH(DELAY_DEPTH)) u_dly (
        .clk(clk), .we(st_reg == ST_RD), .waddr(didx_reg), .wdata(imu_reg),
        .raddr(didx_reg), .rdata(ram_q));

    cord_ctl_t cctl;
    logic cdone;
    logic [15:0] ccos, csin, cang, cin_ang;
    logic [SUM_W-1:0] cxs, cys;
    assign cctl.start = (st_reg == ST_C1) || (st_reg == ST_C2) ||
                        (st_reg == ST_V1) || (st_reg == ST_V2);
    assign cctl.vect = (st_reg == ST_V1) || (st_reg == ST_V2);
    assign cin_ang = (st_reg == ST_C1) ? old_reg : vis_reg;
    assign cxs = (st_reg == ST_V1) ? s2_reg : s0_reg;
    assign cys = (st_reg == ST_V1) ? s3_reg : s1_reg;

    iyoc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .ctl(cctl), .ang_in(cin_ang), .xs_in(cxs),
        .ys_in(cys), .done(cdone), .cos_out(ccos), .sin_out(csin), .ang_out(cang));

    // mismatch test
    logic [15:0] err, aerr_lo, arate_lo;
    logic [16:0] aerr, arate;
    logic [8:0] mis_inc;  // one bit wider: a count of 256 must still exceed persist
    logic mism, need_n, acc_ok;
    assign err = vis_reg - (old_reg + off_reg);
    assign aerr = err[15] ? 17'h10000 - {1'b0, err} : {1'b0, err};
    assign arate = rate_reg[15] ? 17'h10000 - {1'b0, rate_reg} : {1'b0, rate_reg};
    assign aerr_lo = aerr[15:0];
    assign arate_lo = arate[15:0];
    assign mism = aerr > {2'b0, thr_reg};
    assign mis_inc = mism ? {1'b0, mis_reg} + 9'd1 : 9'd0;
    assign need_n = mism ? ((mis_inc > {1'b0, pers_reg}) ? 1'b1 : need_reg) : 1'b0;
    assign acc_ok = (!done_reg || need_n) && valid_reg && (arate < {2'b0, rlim_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            thr_reg <= 15'd45; pers_reg <= 8'd10; cal_reg <= 8'd20; rlim_reg <= 15'd1608;
            didx_reg <= '0; dval_reg <= '0; off_reg <= '0; cnt_reg <= '0;
            s0_reg <= '0; s1_reg <= '0; s2_reg <= '0; s3_reg <= '0;
            mis_reg <= '0; need_reg <= 1'b0; done_reg <= 1'b0; last_reg <= '0;
            m_axis_tvalid <= 1'b0; upd_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESH: thr_reg <= cfg_data;
                    REG_PERSIST: pers_reg <= cfg_data[7:0];
                    REG_CALIB: cal_reg <= cfg_data[7:0];
                    REG_RATE: rlim_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (st_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        imu_reg <= s_axis_tdata[15:0];
                        vis_reg <= s_axis_tdata[31:16];
                        valid_reg <= s_axis_tdata[32];
                        rate_reg <= s_axis_tdata[48:33];
                        upd_reg <= 1'b0;
                        if (s_axis_tuser == CMD_CLEAR)
                        begin
                            done_reg <= 1'b0;
                            st_reg <= ST_OUT;
                        end
                        else st_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    dval_reg[didx_reg] <= 1'b1;
                    st_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    didx_reg <= didx_next;
                    mis_reg <= (mis_inc > {1'b0, pers_reg}) ? 8'd0 : mis_inc[7:0];
                    need_reg <= need_n;
                    if (acc_ok)
                        st_reg <= (cnt_reg > {1'b0, cal_reg}) ? ST_V1 : ST_C1;
                    else
                    begin
                        cnt_reg <= '0;
                        s0_reg <= '0; s1_reg <= '0; s2_reg <= '0; s3_reg <= '0;
                        last_reg <= imu_reg + off_reg;
                        st_reg <= ST_OUT;
                    end
                end
                ST_C1: st_reg <= ST_W1;
                ST_W1:
                    if (cdone)
                    begin
                        s0_reg <= s0_reg + SUM_W'($signed(ccos));
                        s1_reg <= s1_reg + SUM_W'($signed(csin));
                        st_reg <= ST_C2;
                    end
                ST_C2: st_reg <= ST_W2;
                ST_W2:
                    if (cdone)
                    begin
                        s2_reg <= s2_reg + SUM_W'($signed(ccos));
                        s3_reg <= s3_reg + SUM_W'($signed(csin));
                        cnt_reg <= cnt_reg + 1'b1;
                        last_reg <= imu_reg + off_reg;
                        st_reg <= ST_OUT;
                    end
                ST_V1: st_reg <= ST_VW1;
                ST_VW1:
                    if (cdone)
                    begin
                        av_reg <= cang;
                        st_reg <= ST_V2;
                    end
                ST_V2: st_reg <= ST_VW2;
                ST_VW2:
                    if (cdone)
                    begin
                        off_reg <= av_reg - cang;
                        last_reg <= imu_reg + (av_reg - cang);
                        done_reg <= 1'b1; upd_reg <= 1'b1;
                        cnt_reg <= '0;
                        s0_reg <= '0; s1_reg <= '0; s2_reg <= '0; s3_reg <= '0;
                        st_reg <= ST_OUT;
                    end
                ST_OUT:
                begin
                    m_axis_tvalid <= 1'b1;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_RD) old_reg <= dval_reg[didx_reg] ? ram_q : 16'd0;
    end

    assign m_axis_tdata = {6'd0, upd_reg, done_reg, off_reg, last_reg};

    logic unused_ok;
    assign unused_ok = ^{aerr_lo, arate_lo, s_axis_tdata[55:49]};

    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
    a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && upd_reg) |-> done_reg) else $error("update without done");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 9'd256) else $error("sample count overflow");
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import iyoc_pkg::*;

    localparam int DEPTH = 5;
    localparam int STEPS = 16;

    // one sample request as it travels on s_axis
    typedef struct packed {
        logic        cmd;
        logic [15:0] rate;
        logic        vis_ok;
        logic [15:0] vis;
        logic [15:0] imu;
    } sample_t;

    typedef struct packed {
        logic        updated;
        logic        cal_once;
        logic [15:0] offset;
        logic [15:0] yaw;
    } yaw_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    imu_yaw_offset_calibrator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // imu_yaw, vision_yaw, vision_valid, rate_of_turn
        .s_axis_tuser (s_axis_tuser),   // command
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // corrected_yaw, current_offset, cal_once, updated
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------
    // Predictor state: shadow of the calibrator
    // ---------------------------------------------------------------
    logic [14:0] thr_q;
    logic [7:0]  persist_q;
    logic [7:0]  calib_q;
    logic [14:0] rate_lim_q;
    logic [15:0] yaw_hist [DEPTH];
    int          hist_ptr;
    logic [15:0] offset_q;
    int          acc_cnt;
    longint      vec_sum [4];     // imu cos, imu sin, vision cos, vision sin
    int          miss_cnt;
    bit          need_cal;
    bit          cal_done;
    logic [15:0] last_yaw;

    yaw_out_t    yaw_expected [$];
    sample_t     send_q [$];
    int          errors;
    int          n_results;
    int          n_updates;
    int          n_clears;
    bit          calm;            // no idling in the last part
    bit          hold_rx;         // long receiver hold-off

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_val(int i);
        longint t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        return t[i];
    endfunction

    function automatic longint q14_clamp(longint v);
        longint r;
        r = shr_floor(v + 32768, 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    // unit vector of a binary angle, Q1.14
    task automatic unit_vec(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] z32;
        bit          flip;
        longint      x, y, z, dx, dy;
        z32 = {ang, 16'h0000};
        flip = 0;
        x = 652032874;
        y = 0;
        if (z32 > 32'h4000_0000 && z32 < 32'hC000_0000)
        begin
            z32 = z32 - 32'h8000_0000;
            flip = 1;
        end
        z = longint'(signed'(z32));
        for (int i = 0; i < STEPS; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_val(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_val(i);
            end
        end
        c = q14_clamp(flip ? -x : x);
        s = q14_clamp(flip ? -y : y);
    endtask

    function automatic logic [15:0] vec_angle(longint ys, longint xs);
        longint      x, y, dx, dy;
        logic [31:0] z;
        if (xs == 0 && ys == 0) return 16'h0000;
        x = xs * 64;
        y = ys * 64;
        z = 32'h0;
        if (x < 0)
        begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z = z + 32'(atan_val(i));
            end
            else
            begin
                x -= dx; y += dy; z = z - 32'(atan_val(i));
            end
        end
        z = z + 32'd32768;
        return z[31:16];
    endfunction

    function automatic int mag16(logic [15:0] v);
        return v[15] ? 65536 - int'(v) : int'(v);
    endfunction

    task automatic calib_reset();
        thr_q = 15'd45; persist_q = 8'd10; calib_q = 8'd20; rate_lim_q = 15'd1608;
        foreach (yaw_hist[i]) yaw_hist[i] = '0;
        foreach (vec_sum[i]) vec_sum[i] = 0;
        hist_ptr = 0; offset_q = '0; acc_cnt = 0; miss_cnt = 0;
        need_cal = 0; cal_done = 0; last_yaw = '0;
    endtask

    // advance the shadow by one accepted request, queue its result
    task automatic predict_yaw(input sample_t smp);
        logic [15:0] old, err;
        bit          upd;
        longint      c, s;
        yaw_out_t    r;
        upd = 0;
        if (smp.cmd == CMD_CLEAR)
        begin
            cal_done = 0;
            n_clears++;
        end
        else
        begin
            old = yaw_hist[hist_ptr];
            yaw_hist[hist_ptr] = smp.imu;
            hist_ptr = (hist_ptr + 1) % DEPTH;
            err = smp.vis - (old + offset_q);
            if (mag16(err) > int'(thr_q))
                miss_cnt++;
            else
            begin
                miss_cnt = 0;
                need_cal = 0;
            end
            if (miss_cnt > int'(persist_q))
            begin
                miss_cnt = 0;
                need_cal = 1;
            end
            if ((!cal_done || need_cal) && smp.vis_ok && mag16(smp.rate) < int'(rate_lim_q))
            begin
                if (acc_cnt > int'(calib_q))
                begin
                    offset_q = vec_angle(vec_sum[3], vec_sum[2])
                             - vec_angle(vec_sum[1], vec_sum[0]);
                    cal_done = 1;
                    upd = 1;
                    acc_cnt = 0;
                    foreach (vec_sum[i]) vec_sum[i] = 0;
                end
                else
                begin
                    unit_vec(old, c, s);
                    vec_sum[0] += c; vec_sum[1] += s;
                    unit_vec(smp.vis, c, s);
                    vec_sum[2] += c; vec_sum[3] += s;
                    acc_cnt++;
                end
            end
            else
            begin
                acc_cnt = 0;
                foreach (vec_sum[i]) vec_sum[i] = 0;
            end
            last_yaw = smp.imu + offset_q;
        end
        r.yaw = last_yaw;
        r.offset = offset_q;
        r.cal_once = cal_done;
        r.updated = upd;
        yaw_expected.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Driver: requests change at the falling edge, one NBA per step
    // ---------------------------------------------------------------
    int tx_gap = 0;
    bit in_acc;                   // request taken at the last rising edge

    always @(posedge clk)
        in_acc <= s_axis_tvalid && s_axis_tready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_acc)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (send_q.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= 56'(send_q[0][48:0]);
                    s_axis_tuser <= send_q[0].cmd;
                    predict_yaw(send_q.pop_front());
                    if (!calm && $urandom_range(0, 5) == 0)
                        tx_gap <= $urandom_range(1, 3);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // prediction happens when the request is presented; it is committed because
    // tvalid is held until the handshake, and requests are taken in order

    int rx_gap = 0;
    int hold_cnt = 0;

    // long receiver hold-off, counted in cycles
    always @(negedge clk)
    begin
        if (hold_rx)
            hold_cnt <= 400;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(negedge clk)
    begin
        if (hold_cnt > 0)
            m_axis_tready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                rx_gap <= $urandom_range(1, 3);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: sample results at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        yaw_out_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[33:0];
            n_results++;
            if (yaw_expected.size() == 0)
                report_mismatch("unexpected result count", n_results, n_results - 1);
            else
            begin
                want = yaw_expected.pop_front();
                if (got.yaw != want.yaw)
                    report_mismatch("corrected_yaw", signed'(got.yaw), signed'(want.yaw));
                if (got.offset != want.offset)
                    report_mismatch("current_offset", signed'(got.offset),
                                    signed'(want.offset));
                if (got.cal_once != want.cal_once)
                    report_mismatch("calibrated_once", got.cal_once, want.cal_once);
                if (got.updated != want.updated)
                    report_mismatch("offset_updated", got.updated, want.updated);
                if (got.updated)
                    n_updates++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic sample_t mk(bit cmd, int imu, int vis, bit ok, int rate);
        sample_t s;
        s.cmd = cmd; s.imu = 16'(imu); s.vis = 16'(vis);
        s.vis_ok = ok; s.rate = 16'(rate);
        return s;
    endfunction

    task automatic wait_idle();
        while (send_q.size() > 0 || s_axis_tvalid || yaw_expected.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 15'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_THRESH:  thr_q = 15'(val);
            REG_PERSIST: persist_q = 8'(val);
            REG_CALIB:   calib_q = 8'(val);
            default:     rate_lim_q = 15'(val);
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int th, input int pe, input int ca, input int ra);
        cfg_write(REG_THRESH, th);
        cfg_write(REG_PERSIST, pe);
        cfg_write(REG_CALIB, ca);
        cfg_write(REG_RATE, ra);
    endtask

    // a calibration run: slow turn, vision mostly valid, vision off from the delayed IMU by a fixed angle plus jitter
    task automatic queue_calib_run(input int len, input int skew);
        int base, step;
        base = $urandom_range(0, 65535);
        step = $urandom_range(0, 600) - 300;
        for (int i = 0; i < len; i++)
        begin
            int jit;
            jit = $urandom_range(0, 40) - 20;
            send_q.push_back(mk(CMD_SAMPLE, base + i * step,
                                base + (i - DEPTH) * step + skew + jit,
                                $urandom_range(0, 30) != 0,
                                $urandom_range(0, 1200) - 600));
        end
    endtask

    task automatic queue_noise(input int len);
        for (int i = 0; i < len; i++)
            send_q.push_back(mk($urandom_range(0, 15) == 0, $urandom, $urandom,
                                $urandom_range(0, 1), $urandom));
    endtask

    int phase;

    initial
    begin
        errors = 0; n_results = 0; n_updates = 0; n_clears = 0;
        calm = 0; hold_rx = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = CMD_SAMPLE;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0; cfg_index = REG_THRESH; cfg_data = '0;
        calib_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, both commands, edge angles, rate at the limit
        send_q.push_back(mk(CMD_SAMPLE, 32767, -32768, 1, 0));
        send_q.push_back(mk(CMD_SAMPLE, -32768, 32767, 1, -32768));
        send_q.push_back(mk(CMD_SAMPLE, 0, -32768, 1, 1607));
        send_q.push_back(mk(CMD_SAMPLE, 16384, -16384, 1, -1607));
        send_q.push_back(mk(CMD_SAMPLE, 16385, 49151, 1, 1608));
        send_q.push_back(mk(CMD_SAMPLE, -16385, 0, 0, 0));
        send_q.push_back(mk(CMD_CLEAR, 12345, -1, 1, 32767));
        send_q.push_back(mk(CMD_SAMPLE, -1, 1, 1, 5));
        for (int i = 0; i < 14; i++)
            send_q.push_back(mk(CMD_SAMPLE, 0, 0, 1, 0));  // all-zero samples too
        send_q.push_back(mk(CMD_CLEAR, 0, 0, 0, 0));
        wait_idle();

        // receiver holds off while the sender keeps offering requests
        queue_calib_run(30, 1000);
        hold_rx = 1;
        wait (hold_cnt > 0);
        hold_rx = 0;
        wait_idle();

        // several register settings, extremes included
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_regs(0, 1, 1, 32767);
                1: set_regs(32767, 255, 255, 0);
                2: set_regs(45, 10, 20, 1608);
                3: set_regs($urandom_range(0, 300), $urandom_range(1, 8),
                            $urandom_range(1, 12), $urandom_range(500, 4000));
                4: set_regs(10, 2, 3, 32767);
                default:
                begin
                    set_regs(60, 3, 6, 2000);
                    calm = 1;
                end
            endcase
            for (int k = 0; k < 5; k++)
            begin
                queue_calib_run($urandom_range(4, 22), $urandom_range(0, 65535));
                if ($urandom_range(0, 2) == 0)
                    send_q.push_back(mk(CMD_CLEAR, $urandom, $urandom, 1, 0));
                queue_noise($urandom_range(1, 4));
            end
            wait_idle();
        end

        $display("%0d results checked, %0d offset updates, %0d clear requests",
                 n_results, n_updates, n_clears);
        $display("six register settings, a long receiver hold-off, random gaps");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
